// ===== design/amlfe_pkg.sv =====
package amlfe_pkg;

  // Text store depth; the byte counter saturates here
  localparam int MAX_TEXT  = 256;
  localparam int POS_W     = $clog2(MAX_TEXT + 1);
  // Bytes at fixed offsets that any fixed layout reads
  localparam int WIN_BYTES = 50;
  localparam int NFIELDS   = 7;

  // Field slots, also bit positions of the field mask
  localparam int F_SA   = 0;
  localparam int F_DA   = 1;
  localparam int F_ETA  = 2;
  localparam int F_GOUT = 3;
  localparam int F_WOFF = 4;
  localparam int F_WON  = 5;
  localparam int F_GIN  = 6;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef logic [WIN_BYTES-1:0][7:0] win_t;

  typedef struct packed {
    logic                         decoded;
    logic [NFIELDS-1:0]           mask;
    logic [NFIELDS-1:0][31:0]     fld;
  } res_t;

  // Header keyword of the slash layout
  function automatic logic [7:0] ver_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "V";
      3'd1:    c = "E";
      3'd2:    c = "R";
      3'd3:    c = "/";
      3'd4:    c = "0";
      3'd5:    c = "7";
      3'd6:    c = "7";
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] sch_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "S";
      2'd1:    c = "C";
      2'd2:    c = "H";
      default: c = "/";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] eta_char(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "E";
      2'd1:    c = "T";
      2'd2:    c = "A";
      default: c = "/";
    endcase
    return c;
  endfunction

endpackage

// ===== design/amlfe_text_window.sv =====
module amlfe_text_window import amlfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             clear_i,
  input  logic [7:0]       byte_i,
  output logic [POS_W-1:0] pos_o,
  output win_t             view_o
);

  logic [POS_W-1:0] cnt_q, cnt_d;
  win_t             win_q, win_d;

  // Saturate the byte count at the store depth
  always_comb begin
    cnt_d = (cnt_q < POS_W'(MAX_TEXT)) ? cnt_q + POS_W'(1) : cnt_q;
  end

  // Write the new byte at its position; mask positions past the end
  always_comb begin
    for (int i = 0; i < WIN_BYTES; i++) begin
      win_d[i]  = (cnt_q == POS_W'(i)) ? byte_i : win_q[i];
      view_o[i] = (POS_W'(i) < cnt_d) ? win_d[i] : CH_NUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= clear_i ? '0 : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      win_q <= win_d;
    end
  end

  assign pos_o = cnt_q;

endmodule

// ===== design/amlfe_slash_scanner.sv =====
module amlfe_slash_scanner import amlfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       store_i,
  input  logic       clear_i,
  input  logic [2:0] ver_idx_i,
  input  logic [7:0] byte_i,
  output res_t       res_o
);

  typedef enum logic [3:0] {
    S_VER, S_NL, S_SCH, S_SL, S_SRCH, S_ETAM, S_ETAC, S_DONE, S_STOP, S_BAD
  } state_e;

  state_e      st_q, st_d;
  logic [1:0]  off_q, off_d;
  logic        slash_q, slash_d;
  logic [3:0]  dist_q, dist_d;
  logic [31:0] sa_q, sa_d, da_q, da_d, eta_q, eta_d;
  logic        etam_q, etam_d;

  // Advance the scanner by one stored byte
  always_comb begin
    st_d = st_q; off_d = off_q; slash_d = slash_q; dist_d = dist_q;
    sa_d = sa_q; da_d = da_q; eta_d = eta_q; etam_d = etam_q;
    if (store_i) begin
      case (st_q)
        S_VER: begin
          if (byte_i != ver_char(ver_idx_i)) st_d = S_BAD;
          else if (ver_idx_i == 3'd6)        st_d = S_NL;
        end
        S_NL: begin
          if (byte_i == CH_NL) begin
            st_d = S_SCH; off_d = 2'd0;
          end else if (byte_i == CH_NUL) begin
            st_d = S_BAD;
          end
        end
        S_SCH: begin
          if (byte_i != sch_char(off_q)) st_d = S_BAD;
          else if (off_q == 2'd3)        st_d = S_SL;
          else                           off_d = off_q + 2'd1;
        end
        S_SL: begin
          if (byte_i == CH_SLASH) begin
            st_d = S_SRCH; slash_d = 1'b1; dist_d = 4'd0;
          end else if (byte_i == CH_NUL) begin
            st_d = S_BAD;
          end
        end
        S_SRCH: begin
          if (byte_i == CH_NL) begin
            st_d = S_ETAM; off_d = 2'd0;
          end else if (byte_i == CH_NUL) begin
            st_d = S_STOP;
          end
        end
        S_ETAM: begin
          if (byte_i != eta_char(off_q)) begin
            st_d = S_BAD;
          end else if (off_q == 2'd3) begin
            st_d = S_ETAC; off_d = 2'd0; etam_d = 1'b1;
          end else begin
            off_d = off_q + 2'd1;
          end
        end
        S_ETAC: begin
          for (int k = 0; k < 4; k++) begin
            if (off_q == 2'(k)) eta_d[8*(3-k) +: 8] = byte_i;
          end
          if (off_q == 2'd3) st_d = S_DONE;
          else               off_d = off_q + 2'd1;
        end
        default: ;
      endcase
      // Capture origin and destination at fixed distances from the slash
      if (slash_q && (dist_q < 4'd10)) begin
        dist_d = dist_q + 4'd1;
        for (int k = 0; k < 4; k++) begin
          if (dist_d == 4'(k + 1)) sa_d[8*(3-k) +: 8] = byte_i;
          if (dist_d == 4'(k + 6)) da_d[8*(3-k) +: 8] = byte_i;
        end
      end
    end
  end

  // Report the outcome as if the message ended on this byte
  always_comb begin
    res_o             = '0;
    res_o.decoded     = (st_d == S_SRCH) || (st_d == S_STOP) ||
                        (st_d == S_ETAC) || (st_d == S_DONE);
    res_o.mask[F_SA]  = slash_d;
    res_o.mask[F_DA]  = slash_d;
    res_o.mask[F_ETA] = etam_d;
    res_o.fld[F_SA]   = sa_d;
    res_o.fld[F_DA]   = da_d;
    res_o.fld[F_ETA]  = eta_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_VER; off_q <= '0; slash_q <= 1'b0; dist_q <= '0;
      sa_q <= '0; da_q <= '0; eta_q <= '0; etam_q <= 1'b0;
    end else if (adv_i) begin
      if (clear_i) begin
        st_q <= S_VER; off_q <= '0; slash_q <= 1'b0; dist_q <= '0;
        sa_q <= '0; da_q <= '0; eta_q <= '0; etam_q <= 1'b0;
      end else begin
        st_q <= st_d; off_q <= off_d; slash_q <= slash_d; dist_q <= dist_d;
        sa_q <= sa_d; da_q <= da_d; eta_q <= eta_d; etam_q <= etam_d;
      end
    end
  end

endmodule

// ===== design/amlfe_layout_decode.sv =====
module amlfe_layout_decode import amlfe_pkg::*; (
  input  win_t       view_i,
  input  logic [7:0] label_first_i,
  input  logic [7:0] label_second_i,
  input  res_t       slash_i,
  output res_t       res_o
);

  function automatic logic [31:0] get4(win_t v, int p);
    return {v[p], v[p+1], v[p+2], v[p+3]};
  endfunction

  function automatic res_t cap(res_t r, int f, logic [31:0] val);
    res_t t;
    t = r;
    t.fld[f]  = val;
    t.mask[f] = 1'b1;
    return t;
  endfunction

  // Position report, with the base after an optional zero prefix
  function automatic res_t pos_lay(win_t v, int b);
    res_t r;
    r = '0;
    if ((get4(v, b) == "POS0" || get4(v, b) == "ETA0") &&
        (v[b+4] == "2" || v[b+4] == "3") && v[b+23] == ",") begin
      r = cap(r, F_DA, get4(v, b + 24));
      if (v[b+28] == ",") begin
        r = cap(r, F_ETA, get4(v, b + 29));
        if (v[b+33] == "," && v[b+38] == "," && v[b+43] == ",") begin
          r = cap(r, F_ETA, get4(v, b + 44));
          r.decoded = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic res_t comma_pair(win_t v);
    res_t r;
    r = '0;
    if (v[4] == ",") begin
      r = cap(r, F_SA, get4(v, 0));
      r = cap(r, F_DA, get4(v, 5));
      r.decoded = 1'b1;
    end
    return r;
  endfunction

  function automatic res_t q_lay(win_t v, logic [7:0] l1);
    res_t r;
    r = '0;
    r.decoded = 1'b1;
    case (l1)
      "1": begin
        r = cap(r, F_SA, get4(v, 0));    r = cap(r, F_GOUT, get4(v, 4));
        r = cap(r, F_WOFF, get4(v, 8));  r = cap(r, F_WON, get4(v, 12));
        r = cap(r, F_GIN, get4(v, 16));  r = cap(r, F_DA, get4(v, 24));
      end
      "2": begin r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_ETA, get4(v, 4)); end
      "A", "H": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_GOUT, get4(v, 4));
      end
      "B": begin r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_WOFF, get4(v, 4)); end
      "C": begin r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_WON, get4(v, 4)); end
      "D": begin r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_GIN, get4(v, 4)); end
      "E": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_GOUT, get4(v, 4));
        r = cap(r, F_DA, get4(v, 8));
      end
      "F": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_WOFF, get4(v, 4));
        r = cap(r, F_DA, get4(v, 8));
      end
      "G": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_GOUT, get4(v, 4));
        r = cap(r, F_GIN, get4(v, 8));
      end
      "K": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_WON, get4(v, 4));
        r = cap(r, F_DA, get4(v, 8));
      end
      "L": begin
        r = cap(r, F_DA, get4(v, 0)); r = cap(r, F_GIN, get4(v, 8));
        r = cap(r, F_SA, get4(v, 13));
      end
      "M": begin r = cap(r, F_DA, get4(v, 0)); r = cap(r, F_SA, get4(v, 8)); end
      "N": begin r = cap(r, F_DA, get4(v, 4)); r = cap(r, F_ETA, get4(v, 8)); end
      "P": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_DA, get4(v, 4));
        r = cap(r, F_GOUT, get4(v, 8));
      end
      "Q": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_DA, get4(v, 4));
        r = cap(r, F_WOFF, get4(v, 8));
      end
      "R": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_DA, get4(v, 4));
        r = cap(r, F_WON, get4(v, 8));
      end
      "S": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_DA, get4(v, 4));
        r = cap(r, F_GIN, get4(v, 8));
      end
      "T": begin
        r = cap(r, F_SA, get4(v, 0)); r = cap(r, F_DA, get4(v, 4));
        r = cap(r, F_GOUT, get4(v, 8)); r = cap(r, F_GIN, get4(v, 12));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Select the layout by label and check it against the message bytes
  always_comb begin
    res_o = '0;
    case (label_first_i)
      "1": begin
        case (label_second_i)
          "0": if ({get4(view_i, 0), view_i[4]} == "ARR01") begin
            res_o = cap(res_o, F_DA, get4(view_i, 12));
            res_o = cap(res_o, F_ETA, get4(view_i, 16));
            res_o.decoded = 1'b1;
          end
          "1": if (get4(view_i, 13) == "/DS ") begin
            res_o = cap(res_o, F_DA, get4(view_i, 17));
            if ({get4(view_i, 21), view_i[25]} == "/ETA ") begin
              res_o = cap(res_o, F_ETA, get4(view_i, 26));
              res_o.decoded = 1'b1;
            end
          end
          "2", "G": res_o = comma_pair(view_i);
          "5": if ({get4(view_i, 0), view_i[4]} == "FST01") begin
            res_o = cap(res_o, F_SA, get4(view_i, 5));
            res_o = cap(res_o, F_DA, get4(view_i, 9));
            res_o.decoded = 1'b1;
          end
          "7": if (get4(view_i, 0) == "ETA ") begin
            res_o = cap(res_o, F_ETA, get4(view_i, 4));
            if (view_i[8] == ",") begin
              res_o = cap(res_o, F_SA, get4(view_i, 9));
              if (view_i[13] == ",") begin
                res_o = cap(res_o, F_DA, get4(view_i, 14));
                res_o.decoded = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      "2": begin
        case (label_second_i)
          "0": if ({view_i[0], view_i[1], view_i[2]} == "RST") begin
            res_o = cap(res_o, F_SA, get4(view_i, 22));
            res_o = cap(res_o, F_DA, get4(view_i, 26));
            res_o.decoded = 1'b1;
          end
          "1": if (view_i[6] == ",") begin
            res_o = cap(res_o, F_SA, get4(view_i, 7));
            if (view_i[11] == ",") begin
              res_o = cap(res_o, F_DA, get4(view_i, 12));
              res_o.decoded = 1'b1;
            end
          end
          "6": res_o = slash_i;
          "N": if ({get4(view_i, 0), view_i[4]} == "TKO01" && view_i[11] == "/") begin
            res_o = cap(res_o, F_SA, get4(view_i, 20));
            res_o = cap(res_o, F_DA, get4(view_i, 24));
            res_o.decoded = 1'b1;
          end
          "Z": begin
            res_o = cap(res_o, F_DA, get4(view_i, 0));
            res_o.decoded = 1'b1;
          end
          default: ;
        endcase
      end
      "3": begin
        case (label_second_i)
          "3": if (view_i[0] == "," && view_i[20] == ",") begin
            res_o = cap(res_o, F_SA, get4(view_i, 21));
            if (view_i[25] == ",") begin
              res_o = cap(res_o, F_DA, get4(view_i, 26));
              res_o.decoded = 1'b1;
            end
          end
          "9": if ({get4(view_i, 0), view_i[4]} == "GTA01" && view_i[15] == "/") begin
            res_o = cap(res_o, F_SA, get4(view_i, 24));
            res_o = cap(res_o, F_DA, get4(view_i, 28));
            res_o.decoded = 1'b1;
          end
          default: ;
        endcase
      end
      "4": begin
        case (label_second_i)
          "4": begin
            // Skip a "00" prefix; a lone leading zero fails
            if (view_i[0] == "0") begin
              if (view_i[1] == "0") res_o = pos_lay(view_i, 2);
            end else begin
              res_o = pos_lay(view_i, 0);
            end
          end
          "5": if (view_i[0] == "A") begin
            res_o = cap(res_o, F_DA, get4(view_i, 1));
            res_o.decoded = 1'b1;
          end
          default: ;
        endcase
      end
      "8": begin
        case (label_second_i)
          "0": if ({get4(view_i, 6), view_i[10]} == "/DEST") begin
            res_o = cap(res_o, F_DA, get4(view_i, 12));
            res_o.decoded = 1'b1;
          end
          "3": res_o = comma_pair(view_i);
          "D": if (view_i[4] == "," && view_i[35] == ",") begin
            res_o = cap(res_o, F_SA, get4(view_i, 36));
            if (view_i[40] == ",") begin
              res_o = cap(res_o, F_DA, get4(view_i, 41));
              res_o.decoded = 1'b1;
            end
          end
          "E", "S": if (view_i[4] == ",") begin
            res_o = cap(res_o, F_DA, get4(view_i, 0));
            res_o = cap(res_o, F_ETA, get4(view_i, 5));
            res_o.decoded = 1'b1;
          end
          default: ;
        endcase
      end
      "R": if (label_second_i == "B") res_o = slash_i;
      "Q": res_o = q_lay(view_i, label_second_i);
      default: ;
    endcase
  end

endmodule

// ===== design/aircraft_message_label_field_extractor_unit.sv =====
// Datalink message field extractor.
// Input stream: one message text byte per transaction in s_axis_tdata, the
// two label characters in s_axis_tuser, s_axis_tlast on the final byte.
// Output stream: one transaction per message, on its last byte; tuser is
// the decoded flag, tdata holds the field mask and the seven 32-bit fields.
// Throughput: one byte per cycle unless a last byte waits on a stalled
// result, through an input register, combinational layout decode and a
// result register; a last byte moves on into the result register when free.
// Up to 50 leading bytes are kept for the fixed layouts; the slash layout
// is tracked byte by byte by a small scanner.
// Reset clears the byte count, scanner and both valid flags; no result is
// pending afterwards. When the receiver stalls, the result holds and
// non-last bytes still flow; a second last byte waits in the input register
// and s_axis_tready drops until the pending result is taken.
module aircraft_message_label_field_extractor_unit import amlfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] text_byte
  input  logic [15:0]  s_axis_tuser,  // [7:0] label_first, [15:8] label_second
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [6:0] field_mask, [38:7] origin_code, [70:39] dest_code,
  // [102:71] eta_time, [134:103] gate_out_time, [166:135] wheels_off_time,
  // [198:167] wheels_on_time, [230:199] gate_in_time, [231] zero
  output logic [231:0] m_axis_tdata,
  output logic         m_axis_tuser   // [0] decoded
);

  logic             s1_valid_q;
  logic [7:0]       s1_l0_q, s1_l1_q, s1_byte_q;
  logic             s1_last_q;
  logic             out_valid_q;
  res_t             res_q;
  logic             out_free, s1_adv, s_acc, emit;
  logic [POS_W-1:0] pos;
  win_t             view;
  res_t             slash_res, dec_res;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_last_q || out_free);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign emit          = s1_adv && s1_last_q;

  amlfe_text_window u_win (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s1_adv),
    .clear_i (s1_last_q),
    .byte_i  (s1_byte_q),
    .pos_o   (pos),
    .view_o  (view)
  );

  amlfe_slash_scanner u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .store_i   (pos < POS_W'(MAX_TEXT)),
    .clear_i   (s1_last_q),
    .ver_idx_i (pos[2:0]),
    .byte_i    (s1_byte_q),
    .res_o     (slash_res)
  );

  amlfe_layout_decode u_dec (
    .view_i         (view),
    .label_first_i  (s1_l0_q),
    .label_second_i (s1_l1_q),
    .slash_i        (slash_res),
    .res_o          (dec_res)
  );

  // Hold valid flags for the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) s1_valid_q <= s_axis_tvalid;
      if (emit)               out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Load payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_l0_q   <= s_axis_tuser[7:0];
      s1_l1_q   <= s_axis_tuser[15:8];
      s1_byte_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
    if (emit) res_q <= dec_res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.decoded;
  assign m_axis_tdata  = {1'b0, res_q.fld, res_q.mask};

endmodule

// ===== design/amlfe_checker.sv =====
module amlfe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tlast,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // A pending result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A fresh result follows an accepted last-byte transaction
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result without a last byte");

  // With no result pending, input is never blocked
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind aircraft_message_label_field_extractor_unit amlfe_checker u_chk (.*);
